// ===== design/wall_texel_shader_defines.svh =====
// assertion macros for the wall texel shader checker file
// no dependencies; every macro samples on the rising clock edge with active-low reset
`ifndef WALL_TEXEL_SHADER_DEFINES_SVH
`define WALL_TEXEL_SHADER_DEFINES_SVH

// same-cycle implication
`define WTS_ASSERT_IMPLY(label, clock, resetn, cond, expr) \
    label: assert property (@(posedge clock) disable iff (!resetn) (cond) |-> (expr)) \
        else $error("wall texel shader assertion failed");

// next-cycle implication
`define WTS_ASSERT_NEXT(label, clock, resetn, cond, expr) \
    label: assert property (@(posedge clock) disable iff (!resetn) (cond) |=> (expr)) \
        else $error("wall texel shader assertion failed");

`endif

// ===== design/wts_pkg.sv =====
// types, fixed-point constants and lookup functions for the wall texel shader
// no dependencies
`default_nettype none

package wts_pkg;

    typedef logic [2:0][7:0] rgb_t;

    localparam int unsigned COORD_W     = 16;
    localparam int unsigned DIST_PROD_W = 28;
    localparam int unsigned ACC_W       = 25;
    localparam int unsigned PIX_W       = 17;

    localparam logic [16:0] Q_ONE      = 17'd65536;
    localparam logic [11:0] DEPTH_SLOPE = 12'd2294;
    localparam logic [15:0] FADE_BASE  = 16'd22938;
    localparam logic [15:0] FADE_SPAN  = 16'd42598;
    localparam logic [15:0] SEAM_GAIN  = 16'd53740;
    localparam logic [15:0] TEX_BASE   = 16'd60293;
    localparam logic [15:0] TEX_SPAN   = 16'd5243;

    localparam logic [31:0] HASH_X = 32'h9E3779B1;
    localparam logic [31:0] HASH_Y = 32'h85EBCA6B;
    localparam logic [31:0] HASH_M = 32'h7FEB352D;

    // floor(n / 3) for 16-bit n: ceil(2^19 / 3)
    localparam logic [17:0] DIV3_MUL = 18'd174763;
    // floor(n / 255) for 17-bit n: ceil(2^33 / 255)
    localparam logic [25:0] DIV255_MUL = 26'd33686019;

    localparam logic [7:0] MAX_RED   = 8'd132;
    localparam logic [7:0] MAX_GREEN = 8'd125;
    localparam logic [7:0] MAX_BLUE  = 8'd138;

    function automatic logic [15:0] div3(input logic [15:0] n);
        logic [33:0] p;
        p = 34'(n) * 34'(DIV3_MUL);
        return {1'b0, p[33:19]};
    endfunction

    // index 0 red, 1 green, 2 blue
    function automatic rgb_t base_color(input logic [7:0] material);
        rgb_t c;
        unique case (material)
            8'd1:    c = {8'd108, 8'd96,  8'd86};
            8'd2:    c = {8'd138, 8'd125, 8'd70};
            8'd3:    c = {8'd48,  8'd58,  8'd70};
            8'd4:    c = {8'd78,  8'd84,  8'd88};
            8'd5:    c = {8'd48,  8'd68,  8'd92};
            8'd6:    c = {8'd100, 8'd92,  8'd74};
            8'd7:    c = {8'd32,  8'd104, 8'd132};
            default: c = {8'd82,  8'd92,  8'd100};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/wall_texel_shader.sv =====
// wall pixel shader: color table, depth fade, hash texture, seam and light scaling
// depends on wts_pkg
//
// channel   dir   handshake           payload
// pixel     in    in_valid/in_stall   material, distance, row, col, light
// color     out   out_valid/out_stall red, green, blue
//
// eight register stages, the last one is the output register
// one pixel per clock sustained while no output beat is held
// each stage holds one level of parallel multipliers, none wider than 32 by 32
// rst_n clears all stage valid bits asynchronously
// a held output beat freezes every stage; in_stall is high only then
`default_nettype none

module wall_texel_shader
    import wts_pkg::*;
#(
    parameter int COORD_BITS     = 10,
    parameter int DIST_FRAC_BITS = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            material,
    input  wire logic [15:0]           distance,
    input  wire logic [COORD_BITS-1:0] row,
    input  wire logic [COORD_BITS-1:0] col,
    input  wire logic [7:0]            light,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [7:0]                 red,
    output logic [7:0]                 green,
    output logic [7:0]                 blue
);

    localparam int STAGES = 8;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic              advance;

    // stage 1
    logic [DIST_PROD_W-1:0] s1_scaled_reg;
    logic [COORD_W-1:0]     s1_x_reg;
    logic [COORD_W-1:0]     s1_y_reg;
    logic [COORD_W-1:0]     s1_row_reg;
    logic [COORD_W-1:0]     s1_rq_reg;
    rgb_t                   s1_color_reg;
    logic [7:0]             s1_light_reg;
    logic [COORD_W-1:0]     row_ext;
    logic [COORD_W-1:0]     col_half;

    // stage 2
    logic [15:0]            s2_fade_part_reg;
    logic [31:0]            s2_hx_reg;
    logic [31:0]            s2_hy_reg;
    logic                   s2_seam_reg;
    rgb_t                   s2_color_reg;
    logic [7:0]             s2_light_reg;
    logic [DIST_PROD_W-1:0] scaled_sh;
    logic [16:0]            depth;
    logic [32:0]            fade_prod;
    logic [17:0]            rq_times3;
    logic                   seam_row;

    // stage 3
    logic [2:0][ACC_W-1:0]  s3_acc_reg;
    logic [31:0]            s3_hm_reg;
    logic                   s3_seam_reg;
    logic [7:0]             s3_light_reg;
    logic [16:0]            fade;
    logic [31:0]            h_mix;
    logic [31:0]            h_fold;

    // stage 4
    logic [2:0][ACC_W-1:0]  s4_acc_reg;
    logic [15:0]            s4_tp_reg;
    logic                   s4_seam_reg;
    logic [7:0]             s4_light_reg;
    logic [31:0]            h_fin;
    logic [31:0]            tex_prod;

    // stage 5
    logic [2:0][ACC_W-1:0]  s5_acc_reg;
    logic                   s5_seam_reg;
    logic [7:0]             s5_light_reg;
    logic [16:0]            tex;
    logic [2:0][41:0]       tex_mul;

    // stage 6
    logic [2:0][ACC_W-1:0]  s6_acc_reg;
    logic [7:0]             s6_light_reg;
    logic [2:0][40:0]       seam_mul;

    // stage 7
    logic [2:0][PIX_W-1:0]  s7_p_reg;
    logic [2:0][32:0]       light_mul;

    // stage 8
    rgb_t                   s8_rgb_reg;
    logic [2:0][42:0]       div_mul;
    rgb_t                   rgb_next;

    assign advance  = !(vld_reg[STAGES-1] && out_stall);
    assign in_stall = !advance;

    always_comb
    begin
        vld_next = {vld_reg[STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: distance slope, coordinate division, color lookup
    assign row_ext  = COORD_W'(row);
    assign col_half = COORD_W'(col >> 1);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_scaled_reg <= DIST_PROD_W'(distance) * DIST_PROD_W'(DEPTH_SLOPE);
            s1_x_reg      <= div3(col_half);
            s1_y_reg      <= row_ext >> 2;
            s1_row_reg    <= row_ext;
            s1_rq_reg     <= div3(row_ext);
            s1_color_reg  <= base_color(material);
            s1_light_reg  <= light;
        end
    end

    // stage 2: depth term, hash input products, seam row test
    always_comb
    begin
        scaled_sh = s1_scaled_reg >> DIST_FRAC_BITS;
        if (scaled_sh >= DIST_PROD_W'(Q_ONE))
        begin
            depth = '0;
        end
        else
        begin
            depth = Q_ONE - scaled_sh[16:0];
        end
        fade_prod = 33'(FADE_SPAN) * 33'(depth);
        rq_times3 = {2'b00, s1_rq_reg} + {1'b0, s1_rq_reg, 1'b0};
        seam_row  = (s1_row_reg[1:0] == 2'b00) && ({2'b00, s1_row_reg} == rq_times3);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_fade_part_reg <= fade_prod[31:16];
            s2_hx_reg        <= 32'(s1_x_reg) * HASH_X;
            s2_hy_reg        <= 32'(s1_y_reg) * HASH_Y;
            s2_seam_reg      <= seam_row;
            s2_color_reg     <= s1_color_reg;
            s2_light_reg     <= s1_light_reg;
        end
    end

    // stage 3: fade times base color, hash mixing multiply
    always_comb
    begin
        fade   = 17'(FADE_BASE) + {1'b0, s2_fade_part_reg};
        h_mix  = s2_hx_reg ^ s2_hy_reg;
        h_fold = h_mix ^ (h_mix >> 16);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                s3_acc_reg[ch] <= ACC_W'(s2_color_reg[ch]) * ACC_W'(fade);
            end
            s3_hm_reg    <= h_fold * HASH_M;
            s3_seam_reg  <= s2_seam_reg;
            s3_light_reg <= s2_light_reg;
        end
    end

    // stage 4: noise word to texture span
    always_comb
    begin
        h_fin    = s3_hm_reg ^ (s3_hm_reg >> 15);
        tex_prod = 32'(TEX_SPAN) * 32'(h_fin[15:0]);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s4_acc_reg   <= s3_acc_reg;
            s4_tp_reg    <= tex_prod[31:16];
            s4_seam_reg  <= s3_seam_reg;
            s4_light_reg <= s3_light_reg;
        end
    end

    // stage 5: texture factor
    always_comb
    begin
        tex = 17'(TEX_BASE) + {1'b0, s4_tp_reg};
        for (int ch = 0; ch < 3; ch++)
        begin
            tex_mul[ch] = 42'(s4_acc_reg[ch]) * 42'(tex);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                s5_acc_reg[ch] <= tex_mul[ch][ACC_W+15:16];
            end
            s5_seam_reg  <= s4_seam_reg;
            s5_light_reg <= s4_light_reg;
        end
    end

    // stage 6: seam darkening
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            seam_mul[ch] = 41'(s5_acc_reg[ch]) * 41'(SEAM_GAIN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                s6_acc_reg[ch] <= s5_seam_reg ? seam_mul[ch][ACC_W+15:16] : s5_acc_reg[ch];
            end
            s6_light_reg <= s5_light_reg;
        end
    end

    // stage 7: light scaling
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            light_mul[ch] = 33'(s6_acc_reg[ch]) * 33'(s6_light_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                s7_p_reg[ch] <= light_mul[ch][32:16];
            end
        end
    end

    // stage 8: divide by 255 and clamp
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            div_mul[ch] = 43'(s7_p_reg[ch]) * 43'(DIV255_MUL);
            if (div_mul[ch][42:33] > 10'd255)
            begin
                rgb_next[ch] = 8'd255;
            end
            else
            begin
                rgb_next[ch] = div_mul[ch][40:33];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s8_rgb_reg <= rgb_next;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign red       = s8_rgb_reg[0];
    assign green     = s8_rgb_reg[1];
    assign blue      = s8_rgb_reg[2];

endmodule

`default_nettype wire

// ===== design/wts_chk.sv =====
// port-level checker for the wall texel shader, bound to the top level
// depends on wts_pkg and wall_texel_shader_defines.svh
`default_nettype none
`include "wall_texel_shader_defines.svh"

module wts_chk
    import wts_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] red,
    input wire logic [7:0] green,
    input wire logic [7:0] blue
);

    // a held beat stays
    `WTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable({red, green, blue}))

    // backpressure only comes from a held output beat
    `WTS_ASSERT_IMPLY(a_stall_source, clk, rst_n, in_stall, out_valid && out_stall)

    // an open output never blocks input
    `WTS_ASSERT_IMPLY(a_no_idle_stall, clk, rst_n, !out_valid || !out_stall, !in_stall)

    // shading only darkens the table color
    `WTS_ASSERT_IMPLY(a_color_bound, clk, rst_n, out_valid, (red <= MAX_RED) && (green <= MAX_GREEN) && (blue <= MAX_BLUE))

endmodule

bind wall_texel_shader wts_chk u_wts_chk (.*);

`default_nettype wire

// ===== tb/sv/wall_texel_shader_tb.sv =====
// self-checking testbench for wall_texel_shader: directed pixel table, then random pixels
// expected colors: typed or from a fixed-point shading predictor; needs wts_pkg and the rtl
`timescale 1ns / 100ps

module wall_texel_shader_tb;
    import wts_pkg::*;

    localparam int COORD_BITS     = 10;
    localparam int DIST_FRAC_BITS = 8;
    localparam int N_DIRECTED     = 19;
    localparam int N_RANDOM       = 1950;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic [7:0] MAT_DEFAULT  = 8'd0;
    localparam logic [7:0] MAT_TABLE_LO = 8'd1;
    localparam logic [7:0] MAT_TABLE_HI = 8'd7;
    localparam int         SEAM_PERIOD  = 12;
    localparam bit         TYPED        = 1'b1;
    localparam bit         PREDICTED    = 1'b0;

    typedef struct packed {
        logic [7:0]            material;
        logic [15:0]           distance;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        logic [7:0]            light;
    } pixel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    typedef struct packed {
        pixel_t pix;
        bit     known;
        color_t color;
    } pixel_case_t;

    localparam color_t BLACK = '{8'd0, 8'd0, 8'd0};

    // red, green, blue per material slot; slot 0 is the default wall
    localparam logic [23:0] PALETTE [8] = '{
        {8'd100, 8'd92,  8'd82},
        {8'd86,  8'd96,  8'd108},
        {8'd70,  8'd125, 8'd138},
        {8'd70,  8'd58,  8'd48},
        {8'd88,  8'd84,  8'd78},
        {8'd92,  8'd68,  8'd48},
        {8'd74,  8'd92,  8'd100},
        {8'd132, 8'd104, 8'd32}
    };

    localparam pixel_case_t DIRECTED_CASES [N_DIRECTED] = '{
        '{'{MAT_DEFAULT, 16'd0,     10'd0,    10'd0,    8'd0},   TYPED,     BLACK},
        '{'{8'd255,      16'd65535, 10'd1023, 10'd1023, 8'd0},   TYPED,     BLACK},
        '{'{MAT_TABLE_LO, 16'd0,    10'd1,    10'd1,    8'd255}, PREDICTED, BLACK},
        '{'{8'd2,        16'd0,     10'd5,    10'd7,    8'd255}, PREDICTED, BLACK},
        '{'{8'd3,        16'd0,     10'd0,    10'd0,    8'd255}, PREDICTED, BLACK},
        '{'{8'd4,        16'd256,   10'd12,   10'd6,    8'd255}, PREDICTED, BLACK},
        '{'{8'd5,        16'd1024,  10'd24,   10'd600,  8'd255}, PREDICTED, BLACK},
        '{'{8'd6,        16'd4096,  10'd11,   10'd1000, 8'd200}, PREDICTED, BLACK},
        '{'{MAT_TABLE_HI, 16'd0,    10'd13,   10'd13,   8'd255}, PREDICTED, BLACK},
        '{'{8'd8,        16'd0,     10'd100,  10'd100,  8'd255}, PREDICTED, BLACK},
        '{'{8'd255,      16'd7313,  10'd3,    10'd5,    8'd255}, PREDICTED, BLACK},
        '{'{MAT_DEFAULT, 16'd7314,  10'd3,    10'd5,    8'd255}, PREDICTED, BLACK},
        '{'{8'd2,        16'd65535, 10'd1023, 10'd1023, 8'd255}, PREDICTED, BLACK},
        '{'{MAT_TABLE_HI, 16'd1,    10'd1022, 10'd6,    8'd1},   PREDICTED, BLACK},
        '{'{8'd2,        16'hAAAA,  10'h2AA,  10'h155,  8'hAA},  PREDICTED, BLACK},
        '{'{8'h55,       16'h5555,  10'h155,  10'h2AA,  8'h55},  PREDICTED, BLACK},
        '{'{8'hAA,       16'h00FF,  10'h3FF,  10'd0,    8'd128}, PREDICTED, BLACK},
        '{'{MAT_TABLE_HI, 16'd0,    10'd0,    10'd1023, 8'd255}, PREDICTED, BLACK},
        '{'{8'd3,        16'd7000,  10'd48,   10'd5,    8'd254}, PREDICTED, BLACK}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            material;
    logic [15:0]           distance;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic [7:0]            light;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;

    color_t pending_colors[$];
    int     mismatches   = 0;
    int     quiet_cycles = 0;

    wall_texel_shader #(
        .COORD_BITS     (COORD_BITS),
        .DIST_FRAC_BITS (DIST_FRAC_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .material  (material),
        .distance  (distance),
        .row       (row),
        .col       (col),
        .light     (light),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic color_t shade_pixel(input pixel_t p);
        logic [2:0]  slot;
        logic [23:0] base;
        logic [31:0] h;
        logic [63:0] scaled;
        logic [63:0] depth;
        logic [63:0] fade;
        logic [63:0] tex;
        logic [63:0] acc;
        logic [63:0] level;
        logic [7:0]  chan [3];
        bit          seam;
        slot = (p.material >= MAT_TABLE_LO && p.material <= MAT_TABLE_HI) ?
               p.material[2:0] : MAT_DEFAULT[2:0];
        base = PALETTE[slot];
        scaled = (64'(p.distance) * 64'(DEPTH_SLOPE)) >> DIST_FRAC_BITS;
        depth = (scaled >= 64'(Q_ONE)) ? 64'd0 : 64'(Q_ONE) - scaled;
        fade = 64'(FADE_BASE) + ((64'(FADE_SPAN) * depth) >> 16);
        h = (32'(p.col) / 32'd6) * HASH_X;
        h = h ^ ((32'(p.row) / 32'd4) * HASH_Y);
        h = h ^ (h >> 16);
        h = h * HASH_M;
        h = h ^ (h >> 15);
        tex = 64'(TEX_BASE) + ((64'(TEX_SPAN) * 64'(h[15:0])) >> 16);
        seam = (32'(p.row) % SEAM_PERIOD) == 0;
        for (int ch = 0; ch < 3; ch++)
        begin
            acc = 64'(base[23 - 8 * ch -: 8]) * fade;
            acc = (acc * tex) >> 16;
            if (seam)
                acc = (acc * 64'(SEAM_GAIN)) >> 16;
            level = (acc * 64'(p.light)) / (64'd255 * 64'(Q_ONE));
            chan[ch] = (level > 64'd255) ? 8'd255 : level[7:0];
        end
        return '{chan[0], chan[1], chan[2]};
    endfunction

    task automatic drive_pixel(input pixel_t p, input color_t want, input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        material <= p.material;
        distance <= p.distance;
        row      <= p.row;
        col      <= p.col;
        light    <= p.light;
        do
            @(posedge clk);
        while (in_stall);
        pending_colors.push_back(want);
    endtask

    initial
    begin : pixel_source
        pixel_t pix;
        bit     steady;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        material = '0;
        distance = '0;
        row      = '0;
        col      = '0;
        light    = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            pix = DIRECTED_CASES[i].pix;
            drive_pixel(pix, DIRECTED_CASES[i].known ? DIRECTED_CASES[i].color :
                        shade_pixel(pix), $urandom_range(0, 3));
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 128 == 0)
                steady = ($urandom_range(0, 3) == 0);
            pix.material = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                           8'($urandom_range(MAT_TABLE_LO, MAT_TABLE_HI));
            case ($urandom_range(0, 3))
                0:       pix.distance = 16'($urandom_range(0, 65535));
                1:       pix.distance = 16'($urandom_range(7290, 7340));
                default: pix.distance = 16'($urandom_range(0, 8000));
            endcase
            pix.row = ($urandom_range(0, 4) == 0) ?
                      COORD_BITS'(SEAM_PERIOD * $urandom_range(0, 85)) :
                      COORD_BITS'($urandom_range(0, 1023));
            pix.col = COORD_BITS'($urandom_range(0, 1023));
            case ($urandom_range(0, 7))
                0:       pix.light = 8'd0;
                1:       pix.light = 8'd255;
                default: pix.light = 8'($urandom_range(0, 255));
            endcase
            drive_pixel(pix, shade_pixel(pix), steady ? 0 : $urandom_range(0, 3));
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("wall_texel_shader_tb: done, clean");
        else
            $display("wall_texel_shader_tb: done, errors");
        $finish;
    end

    initial
    begin : color_sink
        int beats;
        int hold;
        bit steady;
        beats = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (beats % 128 == 0)
                steady = ($urandom_range(0, 3) == 0);
            hold = steady ? 0 : $urandom_range(0, 3);
            repeat (hold)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            beats++;
        end
    end

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        mismatches++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    endtask

    always @(posedge clk)
    begin : color_check
        color_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_colors.size() == 0)
            begin
                mismatches++;
                $display("%0t: color beat with none expected, got %0d %0d %0d",
                         $time, red, green, blue);
            end
            else
            begin
                want = pending_colors.pop_front();
                if (red !== want.red)
                    report_field("red", want.red, red);
                if (green !== want.green)
                    report_field("green", want.green, green);
                if (blue !== want.blue)
                    report_field("blue", want.blue, blue);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("wall_texel_shader_tb: done, errors");
                $finish;
            end
        end
    end

endmodule
